/* rtl/core/tccr_pkg.sv */
// Shared types and constants of the text cell color resolver.
package tccr_pkg;

   localparam int PALETTE_DEPTH    = 256;
   localparam int ADDR_W           = $clog2(PALETTE_DEPTH);
   localparam int FIRST_DARK_INDEX = 0;
   localparam int LAST_DARK_INDEX  = 7;
   localparam int INTENSE_OFFSET   = 8;
   localparam int HIGHLIGHT_INDEX  = 4;

   localparam int RGB_W   = 24;
   localparam int INDEX_W = 9;
   localparam int PADDR_W = 8;

   localparam logic [INDEX_W-1:0] PSEUDO_FG = 9'd256;
   localparam logic [INDEX_W-1:0] PSEUDO_BG = 9'd257;

   localparam logic [RGB_W-1:0] DEFAULT_FG_RESET = 24'hFFFFFF;
   localparam logic [RGB_W-1:0] DEFAULT_BG_RESET = 24'h000000;

   localparam logic OP_RESOLVE = 1'b0;
   localparam logic OP_WRITE   = 1'b1;

   localparam logic CSR_DEFAULT_FG = 1'b0;
   localparam logic CSR_DEFAULT_BG = 1'b1;

   typedef enum logic [1:0] {
      SRC_PALETTE,
      SRC_DEFAULT_FG,
      SRC_DEFAULT_BG,
      SRC_ZERO
   } color_src_type;

   typedef struct packed {
      logic                 we;
      logic [PADDR_W-1:0]   addr;
      logic [RGB_W-1:0]     rgb;
   } palette_write_type;

   typedef struct packed {
      logic                 re;
      logic [ADDR_W-1:0]    fg_addr;
      logic [ADDR_W-1:0]    bg_addr;
   } palette_read_type;

endpackage

/* rtl/core/tccr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tccr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/tccr_palette.sv */
// Palette store: two read copies, per-entry valid bits and the highlight entry.
module tccr_palette (
   input  logic                         clock,
   input  logic                         reset,
   input  tccr_pkg::palette_write_type  wr,
   input  tccr_pkg::palette_read_type   rd,
   output logic [tccr_pkg::RGB_W-1:0]   fg_rgb,
   output logic [tccr_pkg::RGB_W-1:0]   bg_rgb,
   output logic [tccr_pkg::RGB_W-1:0]   highlight_rgb
);

   localparam logic HL_IN_RANGE = (tccr_pkg::HIGHLIGHT_INDEX < tccr_pkg::PALETTE_DEPTH);

   logic                                 wr_en;
   logic [tccr_pkg::ADDR_W-1:0]          waddr;
   logic [tccr_pkg::PALETTE_DEPTH-1:0]   valid_ff;
   logic                                 fg_valid_ff;
   logic                                 bg_valid_ff;
   logic [tccr_pkg::RGB_W-1:0]           highlight_ff;
   logic [tccr_pkg::RGB_W-1:0]           ram_fg;
   logic [tccr_pkg::RGB_W-1:0]           ram_bg;

   assign wr_en = wr.we &&
                  ({1'b0, wr.addr} < (tccr_pkg::PADDR_W + 1)'(tccr_pkg::PALETTE_DEPTH));
   assign waddr = wr.addr[tccr_pkg::ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fg_valid_ff  <= 1'b0;
         bg_valid_ff  <= 1'b0;
         highlight_ff <= '0;
      end else begin
         if (wr_en) begin
            valid_ff[waddr] <= 1'b1;
         end
         if (rd.re) begin
            fg_valid_ff <= valid_ff[rd.fg_addr];
            bg_valid_ff <= valid_ff[rd.bg_addr];
         end
         if (HL_IN_RANGE && wr_en && (wr.addr == tccr_pkg::PADDR_W'(tccr_pkg::HIGHLIGHT_INDEX))) begin
            highlight_ff <= wr.rgb;
         end
      end
   end

   tccr_ram #(
      .WIDTH(tccr_pkg::RGB_W),
      .DEPTH(tccr_pkg::PALETTE_DEPTH)
   ) u_ram_fg (
      .clock(clock),
      .we(wr_en),
      .waddr(waddr),
      .wdata(wr.rgb),
      .re(rd.re),
      .raddr(rd.fg_addr),
      .rdata(ram_fg)
   );

   tccr_ram #(
      .WIDTH(tccr_pkg::RGB_W),
      .DEPTH(tccr_pkg::PALETTE_DEPTH)
   ) u_ram_bg (
      .clock(clock),
      .we(wr_en),
      .waddr(waddr),
      .wdata(wr.rgb),
      .re(rd.re),
      .raddr(rd.bg_addr),
      .rdata(ram_bg)
   );

   assign fg_rgb        = fg_valid_ff ? ram_fg : '0;
   assign bg_rgb        = bg_valid_ff ? ram_bg : '0;
   assign highlight_rgb = highlight_ff;

endmodule

/* rtl/core/tccr_highlight.sv */
// Selection highlight: blends the highlight entry and keeps it if contrast holds, else swaps.
module tccr_highlight (
   input  logic                         selected,
   input  logic [tccr_pkg::RGB_W-1:0]   text_rgb,
   input  logic [tccr_pkg::RGB_W-1:0]   back_rgb,
   input  logic [tccr_pkg::RGB_W-1:0]   highlight_rgb,
   output logic [tccr_pkg::RGB_W-1:0]   text_out,
   output logic [tccr_pkg::RGB_W-1:0]   back_out,
   output logic                         blended
);

   function automatic logic [7:0] luminance(input logic [tccr_pkg::RGB_W-1:0] c);
      logic [11:0] sum;
      sum = 12'(3 * {4'd0, c[23:16]}) + 12'(12 * {4'd0, c[15:8]}) + {4'd0, c[7:0]};
      return sum[11:4];
   endfunction

   function automatic logic [tccr_pkg::RGB_W-1:0] blend(
      input logic [tccr_pkg::RGB_W-1:0] a,
      input logic [tccr_pkg::RGB_W-1:0] b
   );
      logic [tccr_pkg::RGB_W-1:0] res;
      logic [8:0]                 s;
      for (int k = 0; k < 3; k++) begin
         s = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
         res[8*k +: 8] = s[8:1];
      end
      return res;
   endfunction

   logic [tccr_pkg::RGB_W-1:0] mix;
   logic [7:0]                 text_lum;
   logic [7:0]                 back_lum;
   logic [7:0]                 mix_lum;
   logic [7:0]                 text_diff;
   logic [7:0]                 back_diff;
   logic                       keep_blend;

   always_comb begin
      mix       = blend(highlight_rgb, back_rgb);
      text_lum  = luminance(text_rgb);
      back_lum  = luminance(back_rgb);
      mix_lum   = luminance(mix);
      text_diff = (text_lum >= mix_lum) ? text_lum - mix_lum : mix_lum - text_lum;
      back_diff = (back_lum >= mix_lum) ? back_lum - mix_lum : mix_lum - back_lum;
      keep_blend = text_diff >= back_diff;
      if (!selected) begin
         text_out = text_rgb;
         back_out = back_rgb;
         blended  = 1'b0;
      end else if (keep_blend) begin
         text_out = text_rgb;
         back_out = mix;
         blended  = 1'b1;
      end else begin
         text_out = back_rgb;
         back_out = text_rgb;
         blended  = 1'b0;
      end
   end

endmodule

/* rtl/core/text_cell_color_resolver.sv */
// Text cell color resolver top: index decode, color resolve, highlight, result register.
// A resolve item goes through the stage-one, stage-two and result registers to rsp_tvalid.
// One item per cycle if not stalled; palette reads and all stage registers move together.
// A palette write item takes effect for the very next item and produces no result.
// Synchronous reset clears the pipeline, all palette valid bits and the highlight entry,
// and loads the default colors; there is no clearing pass.
module text_cell_color_resolver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // fg_index[8:0], bg_index[17:9], bold_flag[18], half_bright_flag[19],
   // reverse_flag[20], cursor_here[21], selected_here[22], palette_address[30:23],
   // palette_rgb[54:31], zero pad[55]
   input  logic [55:0] req_tdata,
   // operation[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // foreground_rgb[23:0], background_rgb[47:24], highlight_blended[48], zero pad[55:49]
   output logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int IDXX_W = tccr_pkg::INDEX_W + 1;

   logic [tccr_pkg::RGB_W-1:0] default_fg_ff;
   logic [tccr_pkg::RGB_W-1:0] default_bg_ff;

   logic                           advance;
   logic                           accept;
   logic [tccr_pkg::INDEX_W-1:0]   fg_index;
   logic [tccr_pkg::INDEX_W-1:0]   bg_index;
   logic                           bold_flag;
   logic                           half_bright_flag;
   logic                           reverse_flag;
   logic                           cursor_here;
   logic                           selected_here;

   logic [tccr_pkg::INDEX_W-1:0]   fi;
   logic [tccr_pkg::INDEX_W-1:0]   bi;
   logic                           lift;
   logic [IDXX_W-1:0]              fg_pal;
   tccr_pkg::color_src_type        fg_src;
   tccr_pkg::color_src_type        bg_src;

   tccr_pkg::palette_write_type    pal_wr;
   tccr_pkg::palette_read_type     pal_rd;
   logic [tccr_pkg::RGB_W-1:0]     pal_fg;
   logic [tccr_pkg::RGB_W-1:0]     pal_bg;
   logic [tccr_pkg::RGB_W-1:0]     pal_hl;

   logic                           s1_valid_ff, s1_valid_in;
   tccr_pkg::color_src_type        s1_fg_src_ff, s1_bg_src_ff;
   logic                           s1_half_ff, s1_half_in;
   logic                           s1_sel_ff, s1_cur_ff;

   logic [tccr_pkg::RGB_W-1:0]     fc;
   logic [tccr_pkg::RGB_W-1:0]     bc;

   logic                           s2_valid_ff;
   logic [tccr_pkg::RGB_W-1:0]     s2_text_ff, s2_text_in;
   logic [tccr_pkg::RGB_W-1:0]     s2_back_ff, s2_back_in;
   logic [tccr_pkg::RGB_W-1:0]     s2_hl_ff;
   logic                           s2_sel_ff, s2_cur_ff;

   logic [tccr_pkg::RGB_W-1:0]     hl_text;
   logic [tccr_pkg::RGB_W-1:0]     hl_back;
   logic                           hl_blended;

   logic                           rsp_valid_ff;
   logic [tccr_pkg::RGB_W-1:0]     rsp_fg_ff, rsp_fg_in;
   logic [tccr_pkg::RGB_W-1:0]     rsp_bg_ff, rsp_bg_in;
   logic                           rsp_blended_ff;

   function automatic tccr_pkg::color_src_type classify(input logic [tccr_pkg::INDEX_W-1:0] idx);
      tccr_pkg::color_src_type src;
      if (idx == tccr_pkg::PSEUDO_FG) begin
         src = tccr_pkg::SRC_DEFAULT_FG;
      end else if (idx == tccr_pkg::PSEUDO_BG) begin
         src = tccr_pkg::SRC_DEFAULT_BG;
      end else if (idx[tccr_pkg::INDEX_W-1]) begin
         src = tccr_pkg::SRC_ZERO;
      end else if ({1'b0, idx} < IDXX_W'(tccr_pkg::PALETTE_DEPTH)) begin
         src = tccr_pkg::SRC_PALETTE;
      end else begin
         src = tccr_pkg::SRC_ZERO;
      end
      return src;
   endfunction

   function automatic logic [tccr_pkg::RGB_W-1:0] pick(
      input tccr_pkg::color_src_type    src,
      input logic [tccr_pkg::RGB_W-1:0] pal,
      input logic [tccr_pkg::RGB_W-1:0] dfg,
      input logic [tccr_pkg::RGB_W-1:0] dbg
   );
      logic [tccr_pkg::RGB_W-1:0] c;
      unique case (src)
         tccr_pkg::SRC_PALETTE:    c = pal;
         tccr_pkg::SRC_DEFAULT_FG: c = dfg;
         tccr_pkg::SRC_DEFAULT_BG: c = dbg;
         default:                  c = '0;
      endcase
      return c;
   endfunction

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   assign fg_index         = req_tdata[8:0];
   assign bg_index         = req_tdata[17:9];
   assign bold_flag        = req_tdata[18];
   assign half_bright_flag = req_tdata[19];
   assign reverse_flag     = req_tdata[20];
   assign cursor_here      = req_tdata[21];
   assign selected_here    = req_tdata[22];

   always_ff @(posedge clock) begin
      if (reset) begin
         default_fg_ff <= tccr_pkg::DEFAULT_FG_RESET;
         default_bg_ff <= tccr_pkg::DEFAULT_BG_RESET;
      end else if (csr_we) begin
         if (csr_index == tccr_pkg::CSR_DEFAULT_FG) begin
            default_fg_ff <= csr_wdata;
         end
         if (csr_index == tccr_pkg::CSR_DEFAULT_BG) begin
            default_bg_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      if (reverse_flag != cursor_here) begin
         fi = bg_index;
         bi = fg_index;
      end else begin
         fi = fg_index;
         bi = bg_index;
      end
      lift = bold_flag && !half_bright_flag &&
             ({1'b0, fi} >= IDXX_W'(tccr_pkg::FIRST_DARK_INDEX)) &&
             ({1'b0, fi} <= IDXX_W'(tccr_pkg::LAST_DARK_INDEX));
      if (lift) begin
         fg_pal = {1'b0, fi} + IDXX_W'(tccr_pkg::INTENSE_OFFSET);
         fg_src = (fg_pal < IDXX_W'(tccr_pkg::PALETTE_DEPTH)) ?
                  tccr_pkg::SRC_PALETTE : tccr_pkg::SRC_ZERO;
      end else begin
         fg_pal = {1'b0, fi};
         fg_src = classify(fi);
      end
      bg_src = classify(bi);
   end

   assign pal_wr.we      = accept && (req_tuser == tccr_pkg::OP_WRITE);
   assign pal_wr.addr    = req_tdata[30:23];
   assign pal_wr.rgb     = req_tdata[54:31];
   assign pal_rd.re      = advance;
   assign pal_rd.fg_addr = fg_pal[tccr_pkg::ADDR_W-1:0];
   assign pal_rd.bg_addr = bi[tccr_pkg::ADDR_W-1:0];

   tccr_palette u_palette (
      .clock(clock),
      .reset(reset),
      .wr(pal_wr),
      .rd(pal_rd),
      .fg_rgb(pal_fg),
      .bg_rgb(pal_bg),
      .highlight_rgb(pal_hl)
   );

   assign s1_valid_in = accept && (req_tuser == tccr_pkg::OP_RESOLVE);
   assign s1_half_in  = half_bright_flag && !bold_flag;

   always_comb begin
      fc = pick(s1_fg_src_ff, pal_fg, default_fg_ff, default_bg_ff);
      bc = pick(s1_bg_src_ff, pal_bg, default_fg_ff, default_bg_ff);
      if (s1_half_ff) begin
         fc = (fc >> 1) & 24'h7F7F7F;
      end
      if (s1_cur_ff) begin
         s2_text_in = bc;
         s2_back_in = fc;
      end else begin
         s2_text_in = fc;
         s2_back_in = bc;
      end
   end

   tccr_highlight u_highlight (
      .selected(s2_sel_ff),
      .text_rgb(s2_text_ff),
      .back_rgb(s2_back_ff),
      .highlight_rgb(s2_hl_ff),
      .text_out(hl_text),
      .back_out(hl_back),
      .blended(hl_blended)
   );

   assign rsp_fg_in = s2_cur_ff ? hl_back : hl_text;
   assign rsp_bg_in = s2_cur_ff ? hl_text : hl_back;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_fg_src_ff   <= fg_src;
         s1_bg_src_ff   <= bg_src;
         s1_half_ff     <= s1_half_in;
         s1_sel_ff      <= selected_here;
         s1_cur_ff      <= cursor_here;
         s2_text_ff     <= s2_text_in;
         s2_back_ff     <= s2_back_in;
         s2_hl_ff       <= pal_hl;
         s2_sel_ff      <= s1_sel_ff;
         s2_cur_ff      <= s1_cur_ff;
         rsp_fg_ff      <= rsp_fg_in;
         rsp_bg_ff      <= rsp_bg_in;
         rsp_blended_ff <= hl_blended;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_blended_ff, rsp_bg_ff, rsp_fg_ff};

endmodule

/* rtl/core/tccr_checker.sv */
// Port-level assertions for the text cell color resolver and their bind.
module tccr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result item changed or was dropped.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid after reset.");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("Input ready does not track the result register.");

endmodule

bind text_cell_color_resolver tccr_checker u_tccr_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the text cell color resolver: stream stimulus, predictor, scoreboard.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 200000;
   localparam int RANDOM_PER_PHASE = 184;
   localparam int SHOWN_ERRORS = 10;

   localparam logic [4:0] F_BOLD = 5'b00001;
   localparam logic [4:0] F_HALF = 5'b00010;
   localparam logic [4:0] F_REV  = 5'b00100;
   localparam logic [4:0] F_CUR  = 5'b01000;
   localparam logic [4:0] F_SEL  = 5'b10000;

   typedef struct packed {
      logic                         op;
      logic [tccr_pkg::INDEX_W-1:0] fg_idx;
      logic [tccr_pkg::INDEX_W-1:0] bg_idx;
      logic                         bold;
      logic                         half;
      logic                         rev;
      logic                         cur;
      logic                         sel;
      logic [tccr_pkg::PADDR_W-1:0] addr;
      logic [tccr_pkg::RGB_W-1:0]   rgb;
   } attr_req_type;

   typedef struct packed {
      logic [tccr_pkg::RGB_W-1:0] fg_rgb;
      logic [tccr_pkg::RGB_W-1:0] bg_rgb;
      logic                       blended;
   } colors_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        csr_we;
   logic        csr_index;
   logic [23:0] csr_wdata;

   text_cell_color_resolver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   logic [tccr_pkg::RGB_W-1:0] palette_shadow [tccr_pkg::PALETTE_DEPTH];
   logic [tccr_pkg::RGB_W-1:0] fg_default;
   logic [tccr_pkg::RGB_W-1:0] bg_default;

   attr_req_type pending_reqs[$];
   colors_type   pending_colors[$];
   attr_req_type cur_req;
   logic         req_taken;
   logic         steady;
   int           cycles = 0;
   int           errors = 0;
   int           cells_checked = 0;
   int           blends_seen = 0;
   int           palette_writes = 0;

   function automatic logic [tccr_pkg::RGB_W-1:0] palette_read(int unsigned idx);
      if (idx < tccr_pkg::PALETTE_DEPTH) begin
         return palette_shadow[idx[tccr_pkg::ADDR_W-1:0]];
      end
      return '0;
   endfunction

   function automatic logic [tccr_pkg::RGB_W-1:0] index_color(
      logic [tccr_pkg::INDEX_W-1:0] idx
   );
      if (idx == tccr_pkg::PSEUDO_FG) begin
         return fg_default;
      end
      if (idx == tccr_pkg::PSEUDO_BG) begin
         return bg_default;
      end
      if (idx > 9'd255) begin
         return '0;
      end
      return palette_read(32'(idx));
   endfunction

   function automatic int unsigned luma(logic [tccr_pkg::RGB_W-1:0] c);
      return (3 * 32'(c[23:16]) + 12 * 32'(c[15:8]) + 32'(c[7:0])) / 16;
   endfunction

   function automatic logic [tccr_pkg::RGB_W-1:0] mix(logic [tccr_pkg::RGB_W-1:0] a,
                                                      logic [tccr_pkg::RGB_W-1:0] b);
      logic [tccr_pkg::RGB_W-1:0] m;
      logic [8:0]                 s;
      m = '0;
      for (int ch = 0; ch < 3; ch++) begin
         s = {1'b0, a[ch*8 +: 8]} + {1'b0, b[ch*8 +: 8]};
         m[ch*8 +: 8] = s[8:1];
      end
      return m;
   endfunction

   function automatic colors_type resolve_colors(attr_req_type a);
      logic [tccr_pkg::INDEX_W-1:0] fi;
      logic [tccr_pkg::INDEX_W-1:0] bi;
      logic [tccr_pkg::RGB_W-1:0]   fc;
      logic [tccr_pkg::RGB_W-1:0]   bc;
      logic [tccr_pkg::RGB_W-1:0]   txt;
      logic [tccr_pkg::RGB_W-1:0]   bck;
      logic [tccr_pkg::RGB_W-1:0]   hl;
      logic [tccr_pkg::RGB_W-1:0]   tmp;
      int unsigned                  tl;
      int unsigned                  bl;
      int unsigned                  hlum;
      int unsigned                  dt;
      int unsigned                  db;
      colors_type                   res;
      if (a.rev != a.cur) begin
         fi = a.bg_idx;
         bi = a.fg_idx;
      end else begin
         fi = a.fg_idx;
         bi = a.bg_idx;
      end
      if (a.bold && !a.half && fi >= tccr_pkg::FIRST_DARK_INDEX &&
          fi <= tccr_pkg::LAST_DARK_INDEX) begin
         fc = palette_read(32'(fi) + 32'(tccr_pkg::INTENSE_OFFSET));
      end else begin
         fc = index_color(fi);
      end
      bc = index_color(bi);
      if (a.half && !a.bold) begin
         fc = (fc >> 1) & 24'h7F7F7F;
      end
      res.blended = 1'b0;
      if (a.sel) begin
         // Under the cursor the roles of text and back color are exchanged.
         if (a.cur) begin
            txt = bc;
            bck = fc;
         end else begin
            txt = fc;
            bck = bc;
         end
         hl = mix(palette_read(32'(tccr_pkg::HIGHLIGHT_INDEX)), bck);
         tl = luma(txt);
         bl = luma(bck);
         hlum = luma(hl);
         dt = (tl >= hlum) ? tl - hlum : hlum - tl;
         db = (bl >= hlum) ? bl - hlum : hlum - bl;
         if (dt >= db) begin
            bck = hl;
            res.blended = 1'b1;
         end else begin
            tmp = bck;
            bck = txt;
            txt = tmp;
         end
         if (a.cur) begin
            bc = txt;
            fc = bck;
         end else begin
            fc = txt;
            bc = bck;
         end
      end
      res.fg_rgb = fc;
      res.bg_rgb = bc;
      return res;
   endfunction

   task automatic note_mismatch(input string msg);
      errors++;
      if (errors <= SHOWN_ERRORS) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic add_resolve(input logic [tccr_pkg::INDEX_W-1:0] fg,
                              input logic [tccr_pkg::INDEX_W-1:0] bg,
                              input logic [4:0] flags);
      attr_req_type it;
      it = '0;
      it.op = tccr_pkg::OP_RESOLVE;
      it.fg_idx = fg;
      it.bg_idx = bg;
      it.bold = |(flags & F_BOLD);
      it.half = |(flags & F_HALF);
      it.rev = |(flags & F_REV);
      it.cur = |(flags & F_CUR);
      it.sel = |(flags & F_SEL);
      pending_reqs.push_back(it);
   endtask

   task automatic add_write(input logic [tccr_pkg::PADDR_W-1:0] addr,
                            input logic [tccr_pkg::RGB_W-1:0] rgb);
      attr_req_type it;
      it = '0;
      it.op = tccr_pkg::OP_WRITE;
      it.addr = addr;
      it.rgb = rgb;
      pending_reqs.push_back(it);
   endtask

   // Indices lean toward the dark and intense range and the pseudo indices.
   function automatic logic [tccr_pkg::INDEX_W-1:0] pick_index();
      int k;
      k = $urandom_range(99);
      if (k < 50) begin
         return tccr_pkg::INDEX_W'($urandom_range(15));
      end else if (k < 65) begin
         return ($urandom_range(1) != 0) ? tccr_pkg::PSEUDO_BG : tccr_pkg::PSEUDO_FG;
      end else if (k < 85) begin
         return tccr_pkg::INDEX_W'($urandom_range(255));
      end
      return tccr_pkg::INDEX_W'($urandom_range(511));
   endfunction

   function automatic attr_req_type random_req();
      attr_req_type it;
      logic [31:0]  bits;
      bits = $urandom;
      it.op = ($urandom_range(99) < 20) ? tccr_pkg::OP_WRITE : tccr_pkg::OP_RESOLVE;
      it.fg_idx = pick_index();
      it.bg_idx = pick_index();
      it.bold = bits[0];
      it.half = bits[1];
      it.rev = bits[2];
      it.cur = bits[3];
      it.sel = bits[4];
      it.addr = ($urandom_range(99) < 70) ? tccr_pkg::PADDR_W'($urandom_range(15))
                                          : tccr_pkg::PADDR_W'($urandom_range(255));
      it.rgb = tccr_pkg::RGB_W'($urandom);
      return it;
   endfunction

   task automatic write_default(input logic idx, input logic [tccr_pkg::RGB_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == tccr_pkg::CSR_DEFAULT_FG) begin
         fg_default = val;
      end else begin
         bg_default = val;
      end
   endtask

   task automatic drain_block();
      while (pending_reqs.size() > 0 || req_tvalid || pending_colors.size() > 0) begin
         @(negedge clock);
      end
      repeat (6) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= tccr_pkg::OP_RESOLVE;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= 8)) begin
               cur_req = pending_reqs.pop_front();
               req_tdata <= {1'b0, cur_req.rgb, cur_req.addr, cur_req.sel, cur_req.cur,
                             cur_req.rev, cur_req.half, cur_req.bold, cur_req.bg_idx,
                             cur_req.fg_idx};
               req_tuser <= cur_req.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= 8);
      end
   end

   always @(posedge clock) begin
      colors_type want;
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles.", cycles);
         $display("FAILURE");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
         for (int i = 0; i < tccr_pkg::PALETTE_DEPTH; i++) begin
            palette_shadow[i] = '0;
         end
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            if (cur_req.op == tccr_pkg::OP_WRITE) begin
               if (cur_req.addr < tccr_pkg::PALETTE_DEPTH) begin
                  palette_shadow[cur_req.addr] = cur_req.rgb;
               end
               palette_writes++;
            end else begin
               pending_colors.push_back(resolve_colors(cur_req));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_colors.size() == 0) begin
               note_mismatch($sformatf("result %h arrived with nothing expected", rsp_tdata));
            end else begin
               want = pending_colors.pop_front();
               cells_checked++;
               if (rsp_tdata[48]) begin
                  blends_seen++;
               end
               if (rsp_tdata[23:0] !== want.fg_rgb) begin
                  note_mismatch($sformatf("foreground expected %h got %h",
                                          want.fg_rgb, rsp_tdata[23:0]));
               end
               if (rsp_tdata[47:24] !== want.bg_rgb) begin
                  note_mismatch($sformatf("background expected %h got %h",
                                          want.bg_rgb, rsp_tdata[47:24]));
               end
               if (rsp_tdata[48] !== want.blended) begin
                  note_mismatch($sformatf("blend flag expected %b got %b",
                                          want.blended, rsp_tdata[48]));
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = tccr_pkg::CSR_DEFAULT_FG;
      csr_wdata = '0;
      steady = 1'b0;
      fg_default = tccr_pkg::DEFAULT_FG_RESET;
      bg_default = tccr_pkg::DEFAULT_BG_RESET;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed items run with the reset default colors.
      add_write(8'd0, 24'h000000);
      add_write(8'd255, 24'hFFFFFF);
      add_write(tccr_pkg::PADDR_W'(tccr_pkg::HIGHLIGHT_INDEX), 24'h3060A0);
      add_write(8'd1, 24'h800000);
      add_write(8'd9, 24'hFF4040);
      add_write(8'd2, 24'h00C000);
      add_resolve(tccr_pkg::PSEUDO_FG, tccr_pkg::PSEUDO_BG, 5'b0);
      add_resolve(tccr_pkg::PSEUDO_BG, tccr_pkg::PSEUDO_FG, 5'b0);
      add_resolve(9'd258, 9'd511, 5'b0);
      add_resolve(9'd255, 9'd0, 5'b0);
      add_resolve(9'd1, 9'd2, F_BOLD);
      add_resolve(9'd1, 9'd2, F_BOLD | F_HALF);
      add_resolve(9'd1, 9'd2, F_HALF);
      add_resolve(tccr_pkg::PSEUDO_FG, 9'd2, F_HALF);
      add_resolve(9'd1, 9'd2, F_REV);
      add_resolve(9'd1, 9'd2, F_CUR);
      add_resolve(9'd1, 9'd2, F_REV | F_CUR);
      add_resolve(tccr_pkg::PSEUDO_FG, tccr_pkg::PSEUDO_BG, F_SEL);
      add_resolve(tccr_pkg::PSEUDO_FG, tccr_pkg::PSEUDO_BG, F_SEL | F_CUR);
      add_resolve(9'd2, 9'd1, F_SEL);
      add_resolve(9'd0, 9'd255, F_BOLD | F_HALF | F_REV | F_CUR | F_SEL);
      add_resolve(9'd7, 9'd1, F_BOLD);
      add_resolve(9'd8, 9'd1, F_BOLD);
      add_resolve(9'd511, 9'd258, F_SEL | F_REV);
      drain_block();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               write_default(tccr_pkg::CSR_DEFAULT_FG, 24'h000000);
               write_default(tccr_pkg::CSR_DEFAULT_BG, 24'hFFFFFF);
            end
            1: begin
               write_default(tccr_pkg::CSR_DEFAULT_FG, tccr_pkg::RGB_W'($urandom));
               write_default(tccr_pkg::CSR_DEFAULT_BG, tccr_pkg::RGB_W'($urandom));
               steady = 1'b1;
            end
            default: begin
               write_default(tccr_pkg::CSR_DEFAULT_FG, 24'hFFFFFF);
               write_default(tccr_pkg::CSR_DEFAULT_BG, 24'h000000);
               steady = 1'b0;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pending_reqs.push_back(random_req());
         end
         drain_block();
      end

      if (pending_colors.size() > 0) begin
         note_mismatch($sformatf("%0d results never arrived", pending_colors.size()));
      end
      $display("Resolved %0d cells (%0d with highlight blend) and wrote %0d palette entries,",
               cells_checked, blends_seen, palette_writes);
      $display("across four default color settings; %0d mismatches.", errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
